FILE: rtl/rte_pkg.sv
// Shared types, widths and operation codes of the route table engine.
package rte_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int FUNC_W = 2;
    localparam int ADDR_W = 32;
    localparam int HOP_W  = 16;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    // Request as it travels along the chain of cells. For a lookup the relay and hop
    // fields are replaced by those stored in the matching cell.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] relay;
        logic [HOP_W-1:0]  hops;
        logic [HOP_W-1:0]  fresh;
        logic              found;
        logic              free_found;
        logic [CNT_W-1:0]  removed;
    } pkt_t;

    // Route written into a free cell when an add finds no matching entry.
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] relay;
        logic [HOP_W-1:0]  hops;
        logic [HOP_W-1:0]  fresh;
    } ins_t;

endpackage

FILE: rtl/rte_if.sv
// Request and response channel interfaces of the route table engine.
interface rte_req_if;
    import rte_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] next_hop_addr;
    logic [HOP_W-1:0]  hop_count;
    logic [HOP_W-1:0]  freshness;

    modport source (
        output valid, func, dest_addr, next_hop_addr, hop_count, freshness,
        input  ready
    );
    modport sink (
        input  valid, func, dest_addr, next_hop_addr, hop_count, freshness,
        output ready
    );
endinterface

interface rte_rsp_if;
    import rte_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] found_next_hop;
    logic [HOP_W-1:0]  found_hops;
    logic [CNT_W-1:0]  removed_count;
    logic [CNT_W-1:0]  entry_count;

    modport source (
        output valid, status, found_next_hop, found_hops, removed_count, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_next_hop, found_hops, removed_count, entry_count,
        output ready
    );
endinterface

FILE: rtl/rte_cell.sv
// One table entry with its compare logic and one stage of the request chain.
module rte_cell #(
    parameter int TABLE_DEPTH = rte_pkg::TABLE_DEPTH_DEF,
    parameter int CELL_IDX    = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  rte_pkg::pkt_t                    in_pkt,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   in_free_idx,
    output logic                             out_valid,
    output rte_pkg::pkt_t                    out_pkt,
    output logic [$clog2(TABLE_DEPTH)-1:0]   out_free_idx,
    input  logic                             ins_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   ins_idx,
    input  rte_pkg::ins_t                    ins,
    output logic                             entry_valid
);
    import rte_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic              valid_reg,    valid_next;
    logic [ADDR_W-1:0] dest_reg,     dest_next;
    logic [ADDR_W-1:0] relay_reg,    relay_next;
    logic [HOP_W-1:0]  hops_reg,     hops_next;
    logic [HOP_W-1:0]  fresh_reg,    fresh_next;

    logic              pkt_valid_reg;
    pkt_t              pkt_reg,      pkt_next;
    logic [IDX_W-1:0]  idx_reg,      idx_next;
    logic              hit;

    assign hit = valid_reg && (dest_reg == in_pkt.dest);

    always_comb
    begin
        valid_next    = valid_reg;
        dest_next     = dest_reg;
        relay_next    = relay_reg;
        hops_next     = hops_reg;
        fresh_next    = fresh_reg;
        pkt_next      = in_pkt;
        idx_next      = in_free_idx;

        if (in_valid)
        begin
            case (in_pkt.func)
                FUNC_LOOKUP:
                begin
                    if (hit)
                    begin
                        pkt_next.found = 1'b1;
                        pkt_next.relay = relay_reg;
                        pkt_next.hops  = hops_reg;
                    end
                end
                FUNC_ADD:
                begin
                    if (hit)
                    begin
                        pkt_next.found = 1'b1;
                        if (fresh_reg < in_pkt.fresh)
                        begin
                            relay_next = in_pkt.relay;
                            hops_next  = in_pkt.hops;
                            fresh_next = in_pkt.fresh;
                        end
                    end
                    if (!valid_reg && !in_pkt.free_found)
                    begin
                        pkt_next.free_found = 1'b1;
                        idx_next            = MY_IDX;
                    end
                end
                FUNC_DELETE:
                begin
                    if (hit)
                    begin
                        pkt_next.found = 1'b1;
                        valid_next     = 1'b0;
                    end
                end
                FUNC_CLEAR:
                begin
                    if (valid_reg && (relay_reg == in_pkt.relay))
                    begin
                        valid_next       = 1'b0;
                        pkt_next.removed = in_pkt.removed + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        // A new route lands here after its request has left the chain.
        if (ins_en && (ins_idx == MY_IDX))
        begin
            valid_next = 1'b1;
            dest_next  = ins.dest;
            relay_next = ins.relay;
            hops_next  = ins.hops;
            fresh_next = ins.fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            pkt_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg     <= dest_next;
        relay_reg    <= relay_next;
        hops_reg     <= hops_next;
        fresh_reg    <= fresh_next;
        pkt_reg      <= pkt_next;
        idx_reg      <= idx_next;
    end

    assign out_valid    = pkt_valid_reg;
    assign out_pkt      = pkt_reg;
    assign out_free_idx = idx_reg;
    assign entry_valid  = valid_reg;

endmodule

FILE: rtl/rte_ctrl.sv
// Request intake, result building, entry count and insert commit of the route table.
module rte_ctrl #(
    parameter int TABLE_DEPTH = rte_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rte_req_if.sink                          req,
    rte_rsp_if.source                        rsp,
    output logic                             head_valid,
    output rte_pkg::pkt_t                    head_pkt,
    output logic [$clog2(TABLE_DEPTH)-1:0]   head_free_idx,
    input  logic                             tail_valid,
    input  rte_pkg::pkt_t                    tail_pkt,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   tail_free_idx,
    output logic                             ins_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ins_idx,
    output rte_pkg::ins_t                    ins,
    output logic [rte_pkg::CNT_W-1:0]        entry_total
);
    import rte_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] found_next_hop;
        logic [HOP_W-1:0]  found_hops;
        logic [CNT_W-1:0]  removed_count;
        logic [CNT_W-1:0]  entry_count;
    } rsp_t;

    state_t           state_reg,      state_next;
    logic             head_valid_reg, head_valid_next;
    pkt_t             head_pkt_reg,   head_pkt_next;
    rsp_t             res_reg,        res_next;
    logic             ins_en_reg,     ins_en_next;
    logic [IDX_W-1:0] ins_idx_reg,    ins_idx_next;
    ins_t             ins_data_reg,   ins_data_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic             out_valid_reg,  out_valid_next;
    rsp_t             out_reg,        out_next;

    logic             accept;
    logic             out_free;
    logic             do_insert;
    rsp_t             tail_res;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Result of the request that has just left the last cell.
    always_comb
    begin
        tail_res  = '0;
        do_insert = 1'b0;
        case (tail_pkt.func)
            FUNC_LOOKUP:
            begin
                if (tail_pkt.found)
                begin
                    tail_res.found_next_hop = tail_pkt.relay;
                    tail_res.found_hops     = tail_pkt.hops;
                end
                else
                begin
                    tail_res.status = ST_NOT_FOUND;
                end
            end
            FUNC_ADD:
            begin
                if (!tail_pkt.found)
                begin
                    if (tail_pkt.free_found)
                    begin
                        do_insert = 1'b1;
                    end
                    else
                    begin
                        tail_res.status = ST_FULL;
                    end
                end
            end
            FUNC_DELETE:
            begin
                if (tail_pkt.found)
                begin
                    tail_res.removed_count = CNT_W'(1);
                end
                else
                begin
                    tail_res.status = ST_NOT_FOUND;
                end
            end
            FUNC_CLEAR:
            begin
                tail_res.removed_count = tail_pkt.removed;
            end
            default:
            begin
            end
        endcase
        tail_res.entry_count = count_reg - tail_res.removed_count + CNT_W'(do_insert);
    end

    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = 1'b0;
        head_pkt_next   = head_pkt_reg;
        res_next        = res_reg;
        ins_en_next     = 1'b0;
        ins_idx_next    = ins_idx_reg;
        ins_data_next   = ins_data_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    head_valid_next          = 1'b1;
                    head_pkt_next.func       = req.func;
                    head_pkt_next.dest       = req.dest_addr;
                    head_pkt_next.relay      = req.next_hop_addr;
                    head_pkt_next.hops       = req.hop_count;
                    head_pkt_next.fresh      = req.freshness;
                    head_pkt_next.found      = 1'b0;
                    head_pkt_next.free_found = 1'b0;
                    head_pkt_next.removed    = '0;
                    state_next               = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail_valid)
                begin
                    res_next            = tail_res;
                    count_next          = tail_res.entry_count;
                    ins_en_next         = do_insert;
                    ins_idx_next        = tail_free_idx;
                    ins_data_next.dest  = tail_pkt.dest;
                    ins_data_next.relay = tail_pkt.relay;
                    ins_data_next.hops  = tail_pkt.hops;
                    ins_data_next.fresh = tail_pkt.fresh;
                    state_next          = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_valid_reg <= 1'b0;
            ins_en_reg     <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            ins_en_reg     <= ins_en_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_pkt_reg <= head_pkt_next;
        res_reg      <= res_next;
        ins_idx_reg  <= ins_idx_next;
        ins_data_reg <= ins_data_next;
        out_reg      <= out_next;
    end

    assign head_valid         = head_valid_reg;
    assign head_pkt           = head_pkt_reg;
    assign head_free_idx      = '0;
    assign ins_en             = ins_en_reg;
    assign ins_idx            = ins_idx_reg;
    assign ins                = ins_data_reg;
    assign entry_total        = count_reg;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.found_next_hop = out_reg.found_next_hop;
    assign rsp.found_hops     = out_reg.found_hops;
    assign rsp.removed_count  = out_reg.removed_count;
    assign rsp.entry_count    = out_reg.entry_count;

endmodule

FILE: rtl/route_table_engine.sv
// Top level of the route table engine: controller and chain of table cells.
//
//  Channel | Direction | Payload                                           | Transfer
//  --------+-----------+---------------------------------------------------+--------------------
//  req     | in        | func, dest_addr, next_hop_addr, hop_count,        | req.valid & req.ready
//          |           | freshness                                         |
//  rsp     | out       | status, found_next_hop, found_hops,               | rsp.valid & rsp.ready
//          |           | removed_count, entry_count                        |
//
// A request is registered, passes through each of the TABLE_DEPTH cells of the chain,
// has its result built, and then loads the output register, which drives the response;
// only after that can the next transfer on req be taken.
// Reset clears every valid bit of the table at once; there is no clearing pass.
// The output register separates the two sides: while a response waits on rsp.ready,
// the next request can already be taken and scanned, and it waits for the output
// register only when its own result is ready.
//
// Each cell holds one route and sees the request as it passes by. Lookups, updates,
// deletes and clears act in the cell where they match, so no entry is ever addressed
// from outside except for the insert of a new route. An add records the lowest free
// cell on its way; when it leaves the chain without a matching key, the controller
// broadcasts the new route with that cell index, and only that cell takes it.
module route_table_engine #(
    parameter int TABLE_DEPTH = rte_pkg::TABLE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rte_req_if.sink   req,
    rte_rsp_if.source rsp
);
    import rte_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // Chain links: link 0 is driven by the controller, link TABLE_DEPTH returns to it.
    logic [TABLE_DEPTH:0] chain_valid;
    pkt_t                 chain_pkt [0:TABLE_DEPTH];
    logic [IDX_W-1:0]     chain_idx [0:TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_vec;
    logic                   ins_en;
    logic [IDX_W-1:0]       ins_idx;
    ins_t                   ins;
    logic [CNT_W-1:0]       entry_total;

    rte_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .head_valid    (chain_valid[0]),
        .head_pkt      (chain_pkt[0]),
        .head_free_idx (chain_idx[0]),
        .tail_valid    (chain_valid[TABLE_DEPTH]),
        .tail_pkt      (chain_pkt[TABLE_DEPTH]),
        .tail_free_idx (chain_idx[TABLE_DEPTH]),
        .ins_en        (ins_en),
        .ins_idx       (ins_idx),
        .ins           (ins),
        .entry_total   (entry_total)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        rte_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_valid     (chain_valid[g]),
            .in_pkt       (chain_pkt[g]),
            .in_free_idx  (chain_idx[g]),
            .out_valid    (chain_valid[g+1]),
            .out_pkt      (chain_pkt[g+1]),
            .out_free_idx (chain_idx[g+1]),
            .ins_en       (ins_en),
            .ins_idx      (ins_idx),
            .ins          (ins),
            .entry_valid  (valid_vec[g])
        );
    end

    // At most one request is ever in flight along the chain.
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one request in the cell chain");

    // A new request is only taken when the chain is empty.
    a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (chain_valid == '0))
        else $error("request taken while the chain is busy");

    // When idle, the entry count agrees with the valid bits held in the cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (CNT_W'($countones(valid_vec)) == entry_total))
        else $error("entry count differs from the number of valid cells");

endmodule
